// ===== design/bgc_pkg.sv =====
// shared types and codes of the button gesture classifier
`timescale 1ns / 1ps
package bgc_pkg;

  // event kinds
  localparam logic [1:0] OP_PRESS   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_POLL    = 2'd2;

  // gesture codes
  localparam logic [1:0] G_NONE   = 2'd0;
  localparam logic [1:0] G_CLICK  = 2'd1;
  localparam logic [1:0] G_DOUBLE = 2'd2;
  localparam logic [1:0] G_LONG   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_SHORT_LIMIT = 2'd0;
  localparam logic [1:0] REG_LONG_LIMIT  = 2'd1;
  localparam logic [1:0] REG_WINDOW      = 2'd2;

  // configuration reset values
  localparam logic [31:0] SHORT_LIMIT_RESET = 32'd300;
  localparam logic [31:0] LONG_LIMIT_RESET  = 32'd1000;
  localparam logic [31:0] WINDOW_RESET      = 32'd300;

  // thresholds seen by the classifier
  typedef struct packed {
    logic [31:0] short_press_limit;
    logic [31:0] long_press_limit;
    logic [31:0] second_press_window;
  } bgc_cfg_t;

  // one result of the classifier
  typedef struct packed {
    logic [1:0]  gesture;
    logic [15:0] click_total;
    logic [15:0] double_total;
    logic [15:0] long_total;
    logic [2:0]  phase;
  } bgc_result_t;

endpackage

// ===== design/bgc_cfg.sv =====
// configuration registers of the button gesture classifier
`timescale 1ns / 1ps
module bgc_cfg (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_write,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output bgc_pkg::bgc_cfg_t cfg
);
  import bgc_pkg::*;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_press_limit   <= SHORT_LIMIT_RESET;
      cfg.long_press_limit    <= LONG_LIMIT_RESET;
      cfg.second_press_window <= WINDOW_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SHORT_LIMIT: cfg.short_press_limit   <= cfg_data;
        REG_LONG_LIMIT:  cfg.long_press_limit    <= cfg_data;
        REG_WINDOW:      cfg.second_press_window <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/bgc_fsm.sv =====
// gesture state machine, time stamps and gesture counters
`timescale 1ns / 1ps
module bgc_fsm (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [1:0]           op,
  input  logic [31:0]          now,
  input  bgc_pkg::bgc_cfg_t    cfg,
  output bgc_pkg::bgc_result_t res
);
  import bgc_pkg::*;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HELD     = 3'd1,
    PH_RELEASED = 3'd2,
    PH_SECOND   = 3'd3,
    PH_LONG     = 3'd4
  } phase_t;

  phase_t      state, state_next;
  logic [31:0] press_stamp, press_stamp_next;
  logic [31:0] release_stamp, release_stamp_next;
  logic [15:0] click_count, click_count_next;
  logic [15:0] double_count, double_count_next;
  logic [15:0] long_count, long_count_next;
  logic [1:0]  gesture;
  logic [31:0] held;
  logic [31:0] waited;

  // elapsed times, wrapping
  assign held   = now - press_stamp;
  assign waited = now - release_stamp;

  // transition logic for one event
  always_comb begin
    state_next         = state;
    press_stamp_next   = press_stamp;
    release_stamp_next = release_stamp;
    click_count_next   = click_count;
    double_count_next  = double_count;
    long_count_next    = long_count;
    gesture            = G_NONE;
    case (state)
      PH_HELD: begin
        if (op == OP_RELEASE) begin
          release_stamp_next = now;
          if (held < cfg.short_press_limit) begin
            state_next = PH_RELEASED;
          end else begin
            click_count_next = click_count + 16'd1;
            gesture          = G_CLICK;
            state_next       = PH_IDLE;
          end
        end else if (op == OP_POLL) begin
          if (held > cfg.long_press_limit) begin
            state_next = PH_LONG;
          end
        end
      end
      PH_RELEASED: begin
        if (op == OP_PRESS) begin
          state_next = PH_SECOND;
        end else if (op == OP_POLL) begin
          if (waited > cfg.second_press_window) begin
            click_count_next = click_count + 16'd1;
            gesture          = G_CLICK;
            state_next       = PH_IDLE;
          end
        end
      end
      PH_SECOND: begin
        if (op == OP_RELEASE) begin
          double_count_next = double_count + 16'd1;
          gesture           = G_DOUBLE;
          state_next        = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (op == OP_RELEASE) begin
          long_count_next = long_count + 16'd1;
          gesture         = G_LONG;
          state_next      = PH_IDLE;
        end
      end
      default: begin
        state_next = PH_IDLE;
        if (op == OP_PRESS) begin
          press_stamp_next = now;
          state_next       = PH_HELD;
        end
      end
    endcase
  end

  // result of the event, values after the update
  always_comb begin
    res.gesture      = gesture;
    res.click_total  = click_count_next;
    res.double_total = double_count_next;
    res.long_total   = long_count_next;
    res.phase        = state_next;
  end

  // state update on each processed event
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= PH_IDLE;
      press_stamp   <= '0;
      release_stamp <= '0;
      click_count   <= '0;
      double_count  <= '0;
      long_count    <= '0;
    end else if (step) begin
      state         <= state_next;
      press_stamp   <= press_stamp_next;
      release_stamp <= release_stamp_next;
      click_count   <= click_count_next;
      double_count  <= double_count_next;
      long_count    <= long_count_next;
    end
  end

  // any recognized gesture returns to idle
  assert property (@(posedge clk) disable iff (rst)
    (step && gesture != G_NONE) |=> (state == PH_IDLE))
    else $error("gesture without return to idle");

  // a click bumps the click counter by one
  assert property (@(posedge clk) disable iff (rst)
    (step && gesture == G_CLICK) |=> (click_count == $past(click_count) + 16'd1))
    else $error("click counter not advanced");

  // double click only ends a second press
  assert property (@(posedge clk) disable iff (rst)
    (step && gesture == G_DOUBLE) |-> (state == PH_SECOND && op == OP_RELEASE))
    else $error("double click outside second press");

  // no event, no change of state
  assert property (@(posedge clk) disable iff (rst)
    !step |=> ($stable(state) && $stable(click_count) && $stable(long_count)))
    else $error("state changed without an event");

endmodule

// ===== design/button_gesture_classifier.sv =====
// top level of the button gesture classifier
//
// usage: events (press, release, poll) enter on the in_valid / in_ready
// channel with their 32-bit time stamp; one result transaction per event
// leaves on the out_valid / out_ready channel with the gesture seen and the
// running click, double click and long press totals plus the new phase.
// thresholds are written through cfg_write / cfg_index / cfg_data while the
// block is idle; index 0 short press limit, 1 long press limit, 2 window.
// path: an event waits in the input register, is classified by the transition
// logic and lands in the result register, where its result can be taken.
// throughput: one event per cycle while out_ready stays high, set by the
// combinational transition logic between the input and result registers.
// stall: while out_ready is low the result register holds; one more event
// waits in the input register, then in_ready drops until the result goes.
// reset: empties both registers, clears the phase (idle), stamps and
// counters, and restores the thresholds to 300, 1000 and 300.
`timescale 1ns / 1ps
module button_gesture_classifier (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  operation,
  input  logic [31:0] now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  gesture,
  output logic [15:0] click_total,
  output logic [15:0] double_total,
  output logic [15:0] long_total,
  output logic [2:0]  phase,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import bgc_pkg::*;

  bgc_cfg_t    cfg;
  bgc_result_t res;
  logic        pend_valid;
  logic [1:0]  pend_op;
  logic [31:0] pend_now;
  logic        step;

  // a pending event is classified when the result register is free or being taken
  assign step     = pend_valid && (!out_valid || out_ready);
  assign in_ready = !pend_valid || step;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      pend_valid <= 1'b1;
    end else if (step) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pend_op  <= operation;
      pend_now <= now;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      gesture      <= res.gesture;
      click_total  <= res.click_total;
      double_total <= res.double_total;
      long_total   <= res.long_total;
      phase        <= res.phase;
    end
  end

  bgc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bgc_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .op   (pend_op),
    .now  (pend_now),
    .cfg  (cfg),
    .res  (res)
  );

endmodule

// ===== sim/tb.sv =====
// self-checking testbench for the button gesture classifier
`timescale 1ns / 1ps
module tb;
  import bgc_pkg::*;

  // phase codes as seen on the phase output
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HELD     = 3'd1,
    PH_RELEASED = 3'd2,
    PH_SECOND   = 3'd3,
    PH_LONG     = 3'd4
  } phase_t;

  // event kind with no meaning to the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned EVENTS_PER_SETTING = 136;
  localparam bgc_result_t UNTYPED = '0;

  // one row of the directed table
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] stamp;
    logic        typed;
    bgc_result_t result;
  } event_row_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  operation;
  logic [31:0] now;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  gesture;
  logic [15:0] click_total;
  logic [15:0] double_total;
  logic [15:0] long_total;
  logic [2:0]  phase;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  // tracked state of the classifier
  phase_t      track_phase;
  logic [31:0] track_press;
  logic [31:0] track_release;
  logic [15:0] track_clicks;
  logic [15:0] track_doubles;
  logic [15:0] track_longs;
  logic [31:0] lim_short;
  logic [31:0] lim_long;
  logic [31:0] lim_window;

  bgc_result_t results_due[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int unsigned sent_events = 0;
  logic [31:0] last_stamp = '0;
  bit          gaps_on = 1'b1;
  bit          stalls_on = 1'b1;

  // directed events: extremes, every event kind, ignored events, threshold edges
  event_row_t directed_events [25] = '{
    '{OP_RELEASE, 32'd5,          1'b1, {G_NONE, 16'd0, 16'd0, 16'd0, PH_IDLE}},
    '{OP_UNUSED,  32'hFFFF_FFFF,  1'b1, {G_NONE, 16'd0, 16'd0, 16'd0, PH_IDLE}},
    '{OP_POLL,    32'd0,          1'b1, {G_NONE, 16'd0, 16'd0, 16'd0, PH_IDLE}},
    '{OP_PRESS,   32'hFFFF_FF00,  1'b1, {G_NONE, 16'd0, 16'd0, 16'd0, PH_HELD}},
    '{OP_PRESS,   32'h0000_0010,  1'b1, {G_NONE, 16'd0, 16'd0, 16'd0, PH_HELD}},
    '{OP_POLL,    32'h0000_02E8,  1'b0, UNTYPED},
    '{OP_POLL,    32'h0000_02E9,  1'b0, UNTYPED},
    '{OP_PRESS,   32'h0000_0300,  1'b0, UNTYPED},
    '{OP_RELEASE, 32'h0000_0310,  1'b1, {G_LONG, 16'd0, 16'd0, 16'd1, PH_IDLE}},
    '{OP_PRESS,   32'd1000,       1'b0, UNTYPED},
    '{OP_RELEASE, 32'd1299,       1'b0, UNTYPED},
    '{OP_POLL,    32'd1599,       1'b0, UNTYPED},
    '{OP_POLL,    32'd1600,       1'b0, UNTYPED},
    '{OP_PRESS,   32'd2000,       1'b0, UNTYPED},
    '{OP_RELEASE, 32'd2300,       1'b0, UNTYPED},
    '{OP_PRESS,   32'd3000,       1'b0, UNTYPED},
    '{OP_RELEASE, 32'd3010,       1'b0, UNTYPED},
    '{OP_PRESS,   32'd3020,       1'b0, UNTYPED},
    '{OP_PRESS,   32'd3030,       1'b0, UNTYPED},
    '{OP_POLL,    32'hFFFF_FFFF,  1'b0, UNTYPED},
    '{OP_RELEASE, 32'd3040,       1'b0, UNTYPED},
    '{OP_PRESS,   32'd4000,       1'b0, UNTYPED},
    '{OP_UNUSED,  32'd4001,       1'b0, UNTYPED},
    '{OP_RELEASE, 32'd4002,       1'b0, UNTYPED},
    '{OP_POLL,    32'hFFFF_FFFF,  1'b0, UNTYPED}
  };

  button_gesture_classifier DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .now          (now),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .gesture      (gesture),
    .click_total  (click_total),
    .double_total (double_total),
    .long_total   (long_total),
    .phase        (phase),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_length();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // classify one event and advance the tracked state
  function automatic bgc_result_t classify_event(input logic [1:0] op,
                                                 input logic [31:0] stamp);
    bgc_result_t r;
    logic [31:0] held;
    logic [31:0] waited;
    held = stamp - track_press;
    waited = stamp - track_release;
    r = '0;
    r.gesture = G_NONE;
    case (track_phase)
      PH_HELD: begin
        if (op == OP_RELEASE) begin
          track_release = stamp;
          if (held < lim_short) begin
            track_phase = PH_RELEASED;
          end else begin
            track_clicks = track_clicks + 16'd1;
            r.gesture = G_CLICK;
            track_phase = PH_IDLE;
          end
        end else if (op == OP_POLL && held > lim_long) begin
          track_phase = PH_LONG;
        end
      end
      PH_RELEASED: begin
        if (op == OP_PRESS) begin
          track_phase = PH_SECOND;
        end else if (op == OP_POLL && waited > lim_window) begin
          track_clicks = track_clicks + 16'd1;
          r.gesture = G_CLICK;
          track_phase = PH_IDLE;
        end
      end
      PH_SECOND: begin
        if (op == OP_RELEASE) begin
          track_doubles = track_doubles + 16'd1;
          r.gesture = G_DOUBLE;
          track_phase = PH_IDLE;
        end
      end
      PH_LONG: begin
        if (op == OP_RELEASE) begin
          track_longs = track_longs + 16'd1;
          r.gesture = G_LONG;
          track_phase = PH_IDLE;
        end
      end
      default: begin
        track_phase = PH_IDLE;
        if (op == OP_PRESS) begin
          track_press = stamp;
          track_phase = PH_HELD;
        end
      end
    endcase
    r.click_total = track_clicks;
    r.double_total = track_doubles;
    r.long_total = track_longs;
    r.phase = track_phase;
    return r;
  endfunction

  // present one event, wait for its transaction, record what it should give
  task automatic send_event(input logic [1:0] op, input logic [31:0] stamp,
                            input logic typed = 1'b0,
                            input bgc_result_t given = '0);
    int unsigned pause;
    bgc_result_t predicted;
    pause = gaps_on ? idle_length() : 0;
    if (pause > 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    now <= stamp;
    do @(posedge clk); while (!in_ready);
    predicted = classify_event(op, stamp);
    sent_events++;
    results_due.push_back(typed ? given : predicted);
    last_stamp = stamp;
    @(negedge clk);
  endtask

  // stop sending and wait until every pending result has been taken
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // drive one register write; the caller lowers cfg_write afterwards
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    case (idx)
      REG_SHORT_LIMIT: lim_short = value;
      REG_LONG_LIMIT:  lim_long = value;
      REG_WINDOW:      lim_window = value;
      default: ;
    endcase
  endtask

  // new thresholds, written only while the block is idle
  task automatic apply_settings(input logic [31:0] short_lim, input logic [31:0] long_lim,
                                input logic [31:0] window);
    settle();
    write_reg(REG_SHORT_LIMIT, short_lim);
    write_reg(REG_LONG_LIMIT, long_lim);
    write_reg(REG_WINDOW, window);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // time offset near a threshold, with the odd far-off value
  function automatic logic [31:0] near(input logic [31:0] limit);
    case ($urandom_range(0, 7))
      0: return limit - 32'd1;
      1: return limit;
      2: return limit + 32'd1;
      3: return $urandom;
      4: return limit + $urandom_range(2, 50);
      5: return limit - $urandom_range(2, 50);
      default: return $urandom_range(0, limit);
    endcase
  endfunction

  // one gesture with random timing, or a burst of noise
  task automatic play_gesture();
    logic [31:0] start;
    logic [31:0] lift;
    int unsigned kind;
    start = last_stamp + $urandom_range(1, 5000);
    if ($urandom_range(0, 15) == 0) start = $urandom;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: begin
        // short tap, then polls near the end of the second press window
        send_event(OP_PRESS, start);
        lift = start + near(lim_short);
        send_event(OP_RELEASE, lift);
        repeat ($urandom_range(1, 3)) send_event(OP_POLL, lift + near(lim_window));
      end
      2, 3: begin
        // hold with polls, then release
        send_event(OP_PRESS, start);
        repeat ($urandom_range(0, 2)) send_event(OP_POLL, start + near(lim_long));
        send_event(OP_RELEASE, start + near($urandom_range(0, 1) ? lim_short : lim_long));
      end
      4, 5: begin
        // two taps
        send_event(OP_PRESS, start);
        lift = start + near(lim_short);
        send_event(OP_RELEASE, lift);
        if ($urandom_range(0, 2) == 0) send_event(OP_POLL, lift + near(lim_window));
        send_event(OP_PRESS, lift + $urandom_range(0, 400));
        if ($urandom_range(0, 2) == 0) send_event(OP_POLL, $urandom);
        send_event(OP_RELEASE, last_stamp + $urandom_range(0, 400));
      end
      6, 7: begin
        // long hold
        send_event(OP_PRESS, start);
        repeat ($urandom_range(1, 3)) send_event(OP_POLL, start + near(lim_long));
        send_event(OP_RELEASE, start + near(lim_long));
      end
      default: begin
        // noise, unknown event kinds among it
        repeat ($urandom_range(1, 4)) begin
          send_event(2'($urandom_range(0, 3)),
                     $urandom_range(0, 1) ? $urandom : last_stamp + $urandom_range(0, 2000));
        end
      end
    endcase
  endtask

  // result consumer stalls
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!stalls_on) begin
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = idle_length();
      end
    end
  end

  // compare each result transaction with the oldest pending one
  always @(posedge clk) begin
    bgc_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result transaction with nothing pending");
        fail_count++;
      end else begin
        want = results_due.pop_front();
        if (gesture !== want.gesture) begin
          $error("gesture: expected %0d, actual %0d", want.gesture, gesture);
          fail_count++;
        end
        if (click_total !== want.click_total) begin
          $error("click_total: expected %0d, actual %0d", want.click_total, click_total);
          fail_count++;
        end
        if (double_total !== want.double_total) begin
          $error("double_total: expected %0d, actual %0d", want.double_total, double_total);
          fail_count++;
        end
        if (long_total !== want.long_total) begin
          $error("long_total: expected %0d, actual %0d", want.long_total, long_total);
          fail_count++;
        end
        if (phase !== want.phase) begin
          $error("phase: expected %0d, actual %0d", want.phase, phase);
          fail_count++;
        end
      end
    end
  end

  // stimulus
  initial begin
    int unsigned target;
    int unsigned spins;
    rst = 1'b1;
    in_valid = 1'b0;
    operation = OP_PRESS;
    now = '0;
    cfg_write = 1'b0;
    cfg_index = REG_SHORT_LIMIT;
    cfg_data = '0;
    track_phase = PH_IDLE;
    track_press = '0;
    track_release = '0;
    track_clicks = '0;
    track_doubles = '0;
    track_longs = '0;
    lim_short = SHORT_LIMIT_RESET;
    lim_long = LONG_LIMIT_RESET;
    lim_window = WINDOW_RESET;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed table at reset thresholds
    foreach (directed_events[i]) begin
      send_event(directed_events[i].op, directed_events[i].stamp,
                 directed_events[i].typed, directed_events[i].result);
    end

    // random gestures under several threshold settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: apply_settings(SHORT_LIMIT_RESET, LONG_LIMIT_RESET, WINDOW_RESET);
        1: apply_settings('0, '0, '0);
        2: apply_settings('1, '1, '1);
        3: apply_settings(32'd16, 32'd64, 32'd24);
        4: apply_settings($urandom_range(1, 2000), $urandom_range(1, 5000),
                          $urandom_range(1, 2000));
        default: apply_settings(32'hFFFF_FFFF, 32'd0, $urandom);
      endcase
      target = sent_events + EVENTS_PER_SETTING;
      while (sent_events < target) begin
        if ($urandom_range(0, 29) == 0) begin
          gaps_on = ($urandom_range(0, 3) != 0);
          stalls_on = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 39) == 0) settle();
        play_gesture();
      end
    end

    // drain and finish
    in_valid <= 1'b0;
    spins = 0;
    while (results_due.size() != 0 && spins < 20000) begin
      @(negedge clk);
      spins++;
    end
    if (results_due.size() != 0) begin
      $error("%0d results never arrived", results_due.size());
      fail_count++;
    end
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/bgc_pkg.sv
design/bgc_cfg.sv
design/bgc_fsm.sv
design/button_gesture_classifier.sv
sim/tb.sv
